>>> design/ctd_pkg.sv
// Shared constants, codes and controller/datapath command and status types of the touch detector.
package ctd_pkg;

  // Field widths
  localparam int SAMPLE_W = 12;
  localparam int LEVEL_W  = 15;
  localparam int HOLD_W   = 16;
  localparam int GAIN_W   = 3;
  localparam int KIND_W   = 2;

  // Configuration port
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  // Register indexes, decoded from paddr[2]
  localparam logic REG_HOLD_SAMPLES = 1'b0;
  localparam logic REG_SPREAD_GAIN  = 1'b1;

  // Register reset values
  localparam logic [HOLD_W-1:0] HOLD_SAMPLES_RST = HOLD_W'(100);
  localparam logic [GAIN_W-1:0] SPREAD_GAIN_RST  = GAIN_W'(3);

  // Default window length
  localparam int WINDOW_LENGTH_DEF = 64;

  // Event kinds
  localparam logic [KIND_W-1:0] KIND_PRESS      = 2'd0;
  localparam logic [KIND_W-1:0] KIND_RELEASE    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CALIBRATED = 2'd2;

  // Saturation limits
  localparam logic [LEVEL_W-1:0] DEV_LIMIT   = 15'h7FFF;
  localparam logic [LEVEL_W-1:0] LEVEL_LIMIT = 15'h7FFF;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic wr_en;      // store the accepted sample
    logic rd_en;      // read one store entry
    logic rd_dev;     // read belongs to the deviation pass
    logic rd_first;   // first entry of a pass
    logic mean_load;  // form the window mean from the total
    logic save_win0;  // keep the first window's mean
    logic eval;       // form threshold candidate and stability flag
    logic commit;     // take the threshold and report calibration
    logic det_en;     // run one detection step
  } ctd_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic out_free;   // output register can take a result this cycle
    logic stable;     // second window is stable against the first mean
  } ctd_sts_t;

endpackage

>>> design/ctd_sample_if.sv
// Sample channel: valid/ready handshake carrying one converter reading.
interface ctd_sample_if import ctd_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

>>> design/ctd_event_if.sv
// Event channel: valid/ready handshake carrying one touch event.
interface ctd_event_if import ctd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  event_kind;
  logic [LEVEL_W-1:0] threshold_level;

  modport source (output valid, output event_kind, output threshold_level, input ready);
  modport sink (input valid, input event_kind, input threshold_level, output ready);
endinterface

>>> design/ctd_regs.sv
// APB configuration registers: hold count and spread gain.
module ctd_regs import ctd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output logic [HOLD_W-1:0]  hold_samples_o,
  output logic [GAIN_W-1:0]  spread_gain_o
);

  logic [HOLD_W-1:0] hold_samples_q;
  logic [GAIN_W-1:0] spread_gain_q;
  logic              wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  // Write on the access phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_samples_q <= HOLD_SAMPLES_RST;
      spread_gain_q  <= SPREAD_GAIN_RST;
    end else if (wr_en) begin
      unique case (paddr[2])
        REG_HOLD_SAMPLES: hold_samples_q <= pwdata[HOLD_W-1:0];
        REG_SPREAD_GAIN:  spread_gain_q  <= pwdata[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (paddr[2])
      REG_HOLD_SAMPLES: prdata = PDATA_W'(hold_samples_q);
      REG_SPREAD_GAIN:  prdata = PDATA_W'(spread_gain_q);
      default:          prdata = '0;
    endcase
  end

  assign hold_samples_o = hold_samples_q;
  assign spread_gain_o  = spread_gain_q;

endmodule

>>> design/ctd_dp.sv
// Datapath: sample store, window statistics, reciprocal mean, detection and output register.
module ctd_dp import ctd_pkg::*; #(
  parameter int WINDOW_LENGTH = WINDOW_LENGTH_DEF,
  localparam int Depth = 2 * WINDOW_LENGTH,
  localparam int AW    = $clog2(Depth),
  localparam int DW    = SAMPLE_W + $clog2(WINDOW_LENGTH + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ctd_cmd_t            cmd_i,
  input  logic [AW-1:0]       addr_i,
  input  logic [SAMPLE_W-1:0] sample_i,
  input  logic [HOLD_W-1:0]   hold_samples_i,
  input  logic [GAIN_W-1:0]   spread_gain_i,
  input  logic                out_ready_i,
  output ctd_sts_t            sts_o,
  output logic                out_valid_o,
  output logic [KIND_W-1:0]   event_kind_o,
  output logic [LEVEL_W-1:0]  threshold_level_o
);

  // Reciprocal of the window length, exact for every total below 2**DW
  localparam int RecipShift = DW + $clog2(WINDOW_LENGTH);
  localparam int RecipW     = DW + 2;
  localparam logic [RecipW-1:0] Recip =
    RecipW'(((64'd1 << RecipShift) + 64'(WINDOW_LENGTH) - 64'd1) / 64'(WINDOW_LENGTH));

  // Sample store and read pipeline
  logic [SAMPLE_W-1:0] mem_q [Depth];
  logic [SAMPLE_W-1:0] rd_data_q;
  logic                rd_vld_q;
  logic                rd_dev_q;
  logic                rd_first_q;

  // Window statistics
  logic [DW-1:0]       total_q;
  logic [SAMPLE_W-1:0] peak_q;
  logic [LEVEL_W-1:0]  spread_q;
  logic [SAMPLE_W-1:0] mean_q;
  logic [SAMPLE_W-1:0] mean0_q;
  logic [LEVEL_W-1:0]  cand_q;
  logic                stable_q;

  // Detection state and output register
  logic [LEVEL_W-1:0]  thr_q;
  logic [HOLD_W-1:0]   hold_q;
  logic                evt_vld_q;
  logic [KIND_W-1:0]   evt_kind_q;
  logic [LEVEL_W-1:0]  evt_level_q;

  logic [DW+RecipW-1:0] mean_prod;
  logic [SAMPLE_W-1:0] abs_diff;
  logic [HOLD_W-1:0]   dev_sum;
  logic [SAMPLE_W-1:0] spread_amt;
  logic [LEVEL_W-1:0]  gain_prod;
  logic [LEVEL_W:0]    thr_sum;
  logic [LEVEL_W+1:0]  hi_sum;
  logic [LEVEL_W+1:0]  lo_sum;
  logic                above;
  logic                emit;
  logic [KIND_W-1:0]   emit_kind;
  logic [LEVEL_W-1:0]  emit_level;
  logic [HOLD_W-1:0]   hold_d;

  // Store write and registered read share one address
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem_q[addr_i] <= sample_i;
    end
    rd_data_q <= mem_q[addr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q   <= 1'b0;
      rd_dev_q   <= 1'b0;
      rd_first_q <= 1'b0;
    end else begin
      rd_vld_q   <= cmd_i.rd_en;
      rd_dev_q   <= cmd_i.rd_dev;
      rd_first_q <= cmd_i.rd_first;
    end
  end

  // Absolute deviation, saturated running sum
  assign abs_diff = (rd_data_q >= mean_q) ? (rd_data_q - mean_q) : (mean_q - rd_data_q);
  assign dev_sum  = (rd_first_q ? '0 : HOLD_W'(spread_q)) + HOLD_W'(abs_diff);

  // Truncated mean: total times reciprocal, high bits
  assign mean_prod = (DW+RecipW)'(total_q) * (DW+RecipW)'(Recip);

  // Sum/peak pass, deviation pass, mean
  always_ff @(posedge clk_i) begin
    if (rd_vld_q && !rd_dev_q) begin
      if (rd_first_q) begin
        total_q <= DW'(rd_data_q);
        peak_q  <= rd_data_q;
      end else begin
        total_q <= total_q + DW'(rd_data_q);
        if (rd_data_q > peak_q) begin
          peak_q <= rd_data_q;
        end
      end
    end
    if (rd_vld_q && rd_dev_q) begin
      spread_q <= (dev_sum > HOLD_W'(DEV_LIMIT)) ? DEV_LIMIT : dev_sum[LEVEL_W-1:0];
    end
    if (cmd_i.mean_load) begin
      mean_q <= mean_prod[RecipShift +: SAMPLE_W];
    end
    if (cmd_i.save_win0) begin
      mean0_q <= mean_q;
    end
    if (cmd_i.eval) begin
      cand_q   <= thr_sum[LEVEL_W] ? LEVEL_LIMIT : thr_sum[LEVEL_W-1:0];
      stable_q <= (hi_sum > (LEVEL_W+2)'(mean0_q)) && (lo_sum > (LEVEL_W+2)'(mean_q));
    end
  end

  // Threshold candidate and stability test on the second window
  assign spread_amt = peak_q - mean_q;
  assign gain_prod  = LEVEL_W'(spread_gain_i * spread_amt);
  assign thr_sum    = (LEVEL_W+1)'(mean_q) + (LEVEL_W+1)'(gain_prod);
  assign hi_sum     = (LEVEL_W+2)'(mean_q) + (LEVEL_W+2)'(spread_q);
  assign lo_sum     = (LEVEL_W+2)'(mean0_q) + (LEVEL_W+2)'(spread_q);

  // Detection step and calibration report
  assign above = LEVEL_W'(sample_i) > thr_q;

  always_comb begin
    emit       = 1'b0;
    emit_kind  = KIND_PRESS;
    emit_level = thr_q;
    hold_d     = hold_q;
    if (cmd_i.commit) begin
      emit       = 1'b1;
      emit_kind  = KIND_CALIBRATED;
      emit_level = cand_q;
    end else if (cmd_i.det_en) begin
      if (above) begin
        if (hold_q == '0) begin
          hold_d    = hold_samples_i;
          emit      = 1'b1;
          emit_kind = KIND_PRESS;
        end
      end else if (hold_q != '0) begin
        hold_d = hold_q - HOLD_W'(1);
        if (hold_q == HOLD_W'(1)) begin
          emit      = 1'b1;
          emit_kind = KIND_RELEASE;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q     <= '0;
      hold_q    <= '0;
      evt_vld_q <= 1'b0;
    end else begin
      hold_q <= hold_d;
      if (cmd_i.commit) begin
        thr_q <= cand_q;
      end
      if (emit) begin
        evt_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        evt_vld_q <= 1'b0;
      end
    end
  end

  // Hold the result payload until the transfer
  always_ff @(posedge clk_i) begin
    if (emit) begin
      evt_kind_q  <= emit_kind;
      evt_level_q <= emit_level;
    end
  end

  assign sts_o.out_free    = !evt_vld_q || out_ready_i;
  assign sts_o.stable      = stable_q;
  assign out_valid_o       = evt_vld_q;
  assign event_kind_o      = evt_kind_q;
  assign threshold_level_o = evt_level_q;

endmodule

>>> design/ctd_ctrl.sv
// Controller: collection, two statistics passes per window, mean, evaluation, detection.
module ctd_ctrl import ctd_pkg::*; #(
  parameter int WINDOW_LENGTH = WINDOW_LENGTH_DEF,
  localparam int Depth = 2 * WINDOW_LENGTH,
  localparam int AW    = $clog2(Depth),
  localparam int KW    = $clog2(WINDOW_LENGTH)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  ctd_sts_t      sts_i,
  output ctd_cmd_t      cmd_o,
  output logic [AW-1:0] addr_o
);

  typedef enum logic [3:0] {
    ST_COLLECT,
    ST_SUM,
    ST_SUM_WAIT,
    ST_MEAN,
    ST_DEV,
    ST_DEV_WAIT,
    ST_NEXT,
    ST_EVAL,
    ST_FINISH,
    ST_DETECT
  } state_e;

  state_e          state_q;
  logic [AW-1:0]   fill_q;
  logic [KW-1:0]   k_q;
  logic            win_q;

  logic            accept;
  logic            k_last;
  logic [AW-1:0]   win_base;

  assign in_ready_o = ((state_q == ST_COLLECT) || (state_q == ST_DETECT)) && sts_i.out_free;
  assign accept     = in_valid_i && in_ready_o;
  assign k_last     = k_q == KW'(WINDOW_LENGTH - 1);
  assign win_base   = win_q ? AW'(WINDOW_LENGTH) : '0;

  // Commands and store address
  always_comb begin
    cmd_o  = '0;
    addr_o = win_base + AW'(k_q);
    unique case (state_q)
      ST_COLLECT: begin
        cmd_o.wr_en = accept;
        addr_o      = fill_q;
      end
      ST_SUM: begin
        cmd_o.rd_en    = 1'b1;
        cmd_o.rd_first = k_q == '0;
      end
      ST_MEAN: cmd_o.mean_load = 1'b1;
      ST_DEV: begin
        cmd_o.rd_en    = 1'b1;
        cmd_o.rd_dev   = 1'b1;
        cmd_o.rd_first = k_q == '0;
      end
      ST_NEXT:   cmd_o.save_win0 = !win_q;
      ST_EVAL:   cmd_o.eval = 1'b1;
      ST_FINISH: cmd_o.commit = sts_i.out_free && sts_i.stable;
      ST_DETECT: cmd_o.det_en = accept;
      default: ;
    endcase
  end

  // Sequence state and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_COLLECT;
      fill_q  <= '0;
      k_q     <= '0;
      win_q   <= 1'b0;
    end else begin
      unique case (state_q)
        ST_COLLECT: begin
          if (accept) begin
            if (fill_q == AW'(Depth - 1)) begin
              fill_q  <= '0;
              k_q     <= '0;
              win_q   <= 1'b0;
              state_q <= ST_SUM;
            end else begin
              fill_q <= fill_q + AW'(1);
            end
          end
        end
        ST_SUM: begin
          if (k_last) begin
            k_q     <= '0;
            state_q <= ST_SUM_WAIT;
          end else begin
            k_q <= k_q + KW'(1);
          end
        end
        ST_SUM_WAIT: state_q <= ST_MEAN;
        ST_MEAN: begin
          k_q     <= '0;
          state_q <= ST_DEV;
        end
        ST_DEV: begin
          if (k_last) begin
            k_q     <= '0;
            state_q <= ST_DEV_WAIT;
          end else begin
            k_q <= k_q + KW'(1);
          end
        end
        ST_DEV_WAIT: state_q <= ST_NEXT;
        ST_NEXT: begin
          if (!win_q) begin
            win_q   <= 1'b1;
            state_q <= ST_SUM;
          end else begin
            state_q <= ST_EVAL;
          end
        end
        ST_EVAL: state_q <= ST_FINISH;
        ST_FINISH: begin
          if (sts_i.out_free) begin
            state_q <= sts_i.stable ? ST_DETECT : ST_COLLECT;
          end
        end
        ST_DETECT: state_q <= ST_DETECT;
        default:   state_q <= ST_COLLECT;
      endcase
    end
  end

endmodule

>>> design/calibrated_touch_detector_core.sv
// Calibrated touch detector: top level with channels, registers, controller and datapath.
//
// Samples arrive on smp_i (valid/ready); events leave on evt_o (valid/ready) with
// event_kind (press, release, calibration finished) and the current threshold_level.
// After reset the block calibrates: it takes 2*WINDOW_LENGTH samples, one per cycle,
// into its sample store. It then runs, per window, a sum/peak pass over the store,
// a step that forms the mean by reciprocal multiplication and a deviation pass,
// then evaluation and report, all with smp_i not ready. The store's single port
// sets the length of the passes. A stable result reports the threshold and
// starts detection; otherwise the store is filled again.
// While detecting, a sample is taken whenever the output register is free; a press or release is in the output
// register on the cycle after the sample transfer.
// The output register decouples the channels: a new sample is taken while the last
// event is being transferred, and a stalled receiver holds off smp_i only when a
// pending event has not been transferred yet.
// Reset clears the calibration, the threshold and the hold counter and loads the
// registers with hold_samples = 100 and spread_gain = 3 (APB, offsets 0 and 4).
module calibrated_touch_detector_core import ctd_pkg::*; #(
  parameter int WINDOW_LENGTH = WINDOW_LENGTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  ctd_sample_if.sink         smp_i,
  ctd_event_if.source        evt_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  localparam int AW = $clog2(2 * WINDOW_LENGTH);

  logic [HOLD_W-1:0] hold_samples;
  logic [GAIN_W-1:0] spread_gain;
  ctd_cmd_t          cmd;
  ctd_sts_t          sts;
  logic [AW-1:0]     mem_addr;
  logic              in_ready;

  ctd_regs u_regs (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .hold_samples_o (hold_samples),
    .spread_gain_o  (spread_gain)
  );

  ctd_ctrl #(.WINDOW_LENGTH(WINDOW_LENGTH)) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (smp_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .addr_o     (mem_addr)
  );

  ctd_dp #(.WINDOW_LENGTH(WINDOW_LENGTH)) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .addr_i            (mem_addr),
    .sample_i          (smp_i.sample),
    .hold_samples_i    (hold_samples),
    .spread_gain_i     (spread_gain),
    .out_ready_i       (evt_o.ready),
    .sts_o             (sts),
    .out_valid_o       (evt_o.valid),
    .event_kind_o      (evt_o.event_kind),
    .threshold_level_o (evt_o.threshold_level)
  );

  assign smp_i.ready = in_ready;

  // A sample is only taken when its possible event has room
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    smp_i.ready |-> (!evt_o.valid || evt_o.ready))
    else $error("sample taken while output register is blocked");

  // Press and release events follow a sample transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($rose(evt_o.valid) && (evt_o.event_kind != KIND_CALIBRATED))
      |-> $past(smp_i.valid && smp_i.ready))
    else $error("press or release without a sample transfer");

endmodule
